FILE: rtl/bsa_pkg.sv
// Shared types and codes for the bitmap slot allocator.
package bsa_pkg;

   localparam int SLOT_IDX_W = 12;
   localparam int SLOT_RSP_W = 13;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef struct packed {
      action_type              action;
      logic [SLOT_IDX_W-1:0]   slot_index;
   } req_type;

   typedef struct packed {
      logic [SLOT_RSP_W-1:0]   slot;
      logic                    full_res;
   } rsp_type;

endpackage

FILE: rtl/bitmap_slot_allocator.sv
// First-free slot allocator over a usage bitmap held in an internal memory.
// Allocate: issue the first word read, then check one map word per cycle while the next
//   is read, until a clear bit below SLOT_COUNT is found or the last word shows the map full.
// Free: index check, word read and write-back. One item at a time.
// The result strobes in the first idle cycle and cannot be stalled; a new item may start then.
// Reset clears the per-word valid flags at once, so every slot reads free with no clearing pass.
module bitmap_slot_allocator #(
   parameter int SLOT_COUNT    = 4096,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bsa_pkg::req_type req_data,
   output logic             rsp_valid,
   output bsa_pkg::rsp_type rsp_data
);
   import bsa_pkg::*;

   // MAP_WORD_BITS must be a power of two (the block does not enforce it): slot s sits in word s >> BW, bit s[BW-1:0]
   localparam int MAP_WORDS = (SLOT_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BW        = $clog2(MAP_WORD_BITS);
   localparam int CW        = $clog2(SLOT_COUNT + MAP_WORD_BITS);
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ALLOC = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_FRD   = 5'b01000,
      ST_FWR   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // map storage and its per-word valid flags
   logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0]     word_vld_ff;
   logic [MAP_WORD_BITS-1:0] rd_data_ff;
   logic                     rd_vld_ff;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [MAP_WORD_BITS-1:0] wr_data;
   logic [MAP_WORD_BITS-1:0] cur_word;

   // scan state
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic          scan_done_ff, scan_done_in;
   logic          chk_live_ff, chk_live_in;
   logic          chk_last_ff, chk_last_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;
   logic [CW-1:0] base_ff, base_in;

   // free path
   logic [AW-1:0]         div_word_ff, div_word_in;
   logic [SLOT_IDX_W-1:0] echo_idx_ff, echo_idx_in;
   logic                  idx_ok_ff, idx_ok_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic          fz_found;
   logic [BW-1:0] fz_pos;
   logic [CW-1:0] cand_slot;
   logic          accept;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign cur_word  = rd_vld_ff ? rd_data_ff : '0;
   assign rd_addr   = (state_ff == ST_FRD) ? div_word_ff : scan_addr_ff;
   assign cand_slot = base_ff + CW'(fz_pos);

   // lowest clear bit of the word under check
   always_comb begin
      fz_found = 1'b0;
      fz_pos   = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (!cur_word[i]) begin
            fz_found = 1'b1;
            fz_pos   = BW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            word_vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= word_vld_ff[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_addr_in = scan_addr_ff;
      scan_done_in = scan_done_ff;
      chk_live_in  = chk_live_ff;
      chk_last_in  = chk_last_ff;
      chk_addr_in  = chk_addr_ff;
      base_in      = base_ff;
      div_word_in  = div_word_ff;
      echo_idx_in  = echo_idx_ff;
      idx_ok_in    = idx_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = chk_addr_ff;
      wr_data      = cur_word | (MAP_WORD_BITS'(1) << fz_pos);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               scan_addr_in = '0;
               scan_done_in = 1'b0;
               chk_live_in  = 1'b0;
               base_in      = '0;
               div_word_in  = AW'(req_data.slot_index >> BW);
               echo_idx_in  = req_data.slot_index;
               idx_ok_in    = (32'(req_data.slot_index) < 32'(SLOT_COUNT));
               state_in     = (req_data.action == ACT_FREE) ? ST_DIV : ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            // issue the next word read while the previous one is checked
            chk_live_in  = !scan_done_ff;
            chk_addr_in  = scan_addr_ff;
            chk_last_in  = (scan_addr_ff == LAST_WORD);
            if (!scan_done_ff) begin
               if (scan_addr_ff == LAST_WORD) begin
                  scan_done_in = 1'b1;
               end else begin
                  scan_addr_in = scan_addr_ff + AW'(1);
               end
            end
            if (chk_live_ff) begin
               if (fz_found && (cand_slot < CW'(SLOT_COUNT))) begin
                  wr_en                = 1'b1;
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.slot     = SLOT_RSP_W'(cand_slot);
                  rsp_data_in.full_res = 1'b0;
                  state_in             = ST_IDLE;
               end else if (fz_found || chk_last_ff) begin
                  // no clear bit, or only bits past the last slot are clear: map is full
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.slot     = SLOT_RSP_W'(SLOT_COUNT);
                  rsp_data_in.full_res = 1'b1;
                  state_in             = ST_IDLE;
               end else begin
                  base_in = base_ff + CW'(MAP_WORD_BITS);
               end
            end
         end
         ST_DIV: begin
            // drop an index past the last slot: echo it and leave the map alone
            if (!idx_ok_ff) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.slot     = SLOT_RSP_W'(echo_idx_ff);
               rsp_data_in.full_res = 1'b0;
               state_in             = ST_IDLE;
            end else begin
               state_in = ST_FRD;
            end
         end
         ST_FRD: begin
            state_in = ST_FWR;
         end
         ST_FWR: begin
            wr_en                = 1'b1;
            wr_addr              = div_word_ff;
            wr_data              = cur_word & ~(MAP_WORD_BITS'(1) << echo_idx_ff[BW-1:0]);
            rsp_valid_in         = 1'b1;
            rsp_data_in.slot     = SLOT_RSP_W'(echo_idx_ff);
            rsp_data_in.full_res = 1'b0;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         scan_done_ff <= 1'b0;
         chk_live_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_done_ff <= scan_done_in;
         chk_live_ff  <= chk_live_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      chk_last_ff  <= chk_last_in;
      chk_addr_ff  <= chk_addr_in;
      base_ff      <= base_in;
      div_word_ff  <= div_word_in;
      echo_idx_ff  <= echo_idx_in;
      idx_ok_ff    <= idx_ok_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_rsp_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not start work");

   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.full_res |-> rsp_data.slot == SLOT_RSP_W'(SLOT_COUNT))
      else $error("full result without slot count");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_ALLOC) || (state_ff == ST_FWR))
      else $error("map write outside allocate or free write-back");

   a_write_ends_item: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid)
      else $error("map write not followed by a result");

endmodule
